### src/sts_pkg.sv
package sts_pkg;

    localparam int TableDepth = 64;
    localparam int KeyWidth   = 16;

    localparam logic [6:0]  VALID_BITS_RST = 7'd64;
    localparam logic [31:0] TICK_SCALE_RST = 32'd65536;
    localparam logic [16:0] ALPHA_RST      = 17'd6554;

    localparam logic [1:0] REG_VALID_BITS = 2'd0;
    localparam logic [1:0] REG_TICK_SCALE = 2'd1;
    localparam logic [1:0] REG_ALPHA      = 2'd2;

    localparam logic [1:0] ST_UPDATED  = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_CLEARED  = 2'd3;

    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic [31:0] last;
        logic [47:0] average;
        logic [31:0] maximum;
        logic [31:0] count;
        logic [5:0]  depth;
    } t_stats;

endpackage

### src/sts_scaler.sv
module sts_scaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_ticks,
    input  logic [31:0] i_scale,
    output logic        o_done,
    output logic [31:0] o_duration
);

    logic [63:0] r_lo_prod, n_lo_prod;
    logic [63:0] r_hi_prod, n_hi_prod;
    logic [31:0] r_hi_ticks, n_hi_ticks;
    logic [31:0] r_scale, n_scale;
    logic [1:0]  r_step, n_step;
    logic [31:0] r_dur, n_dur;
    logic        r_done, n_done;
    logic [48:0] q_sum;

    assign q_sum = {1'b0, r_lo_prod[63:16]} + {r_hi_prod[32:0], 16'd0};

    always_comb begin
        n_lo_prod  = r_lo_prod;
        n_hi_prod  = r_hi_prod;
        n_hi_ticks = r_hi_ticks;
        n_scale    = r_scale;
        n_step     = r_step;
        n_dur      = r_dur;
        n_done     = 1'b0;
        if (i_start) begin
            n_lo_prod  = 64'(i_ticks[31:0]) * 64'(i_scale);
            n_hi_ticks = i_ticks[63:32];
            n_scale    = i_scale;
            n_step     = 2'd1;
        end else if (r_step == 2'd1) begin
            n_hi_prod = 64'(r_hi_ticks) * 64'(r_scale);
            n_step    = 2'd2;
        end else if (r_step == 2'd2) begin
            if (r_hi_prod >= 64'd65536 || q_sum[48:32] != 17'd0) begin
                n_dur = 32'hFFFF_FFFF;
            end else begin
                n_dur = q_sum[31:0];
            end
            n_done = 1'b1;
            n_step = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_prod  <= n_lo_prod;
        r_hi_prod  <= n_hi_prod;
        r_hi_ticks <= n_hi_ticks;
        r_scale    <= n_scale;
        r_dur      <= n_dur;
        if (!i_rst_n) begin
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_done <= n_done;
        end
    end

    assign o_done     = r_done;
    assign o_duration = r_dur;

endmodule

### src/sts_mem.sv
module sts_mem #(
    parameter int DEPTH = sts_pkg::TableDepth,
    parameter int KW    = sts_pkg::KeyWidth,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [KW-1:0]        o_rd_key,
    output sts_pkg::t_stats      o_rd_stats,
    input  logic                 i_wr_en,
    input  logic                 i_wr_key_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [KW-1:0]        i_wr_key,
    input  sts_pkg::t_stats      i_wr_stats
);

    logic [KW-1:0]   r_keys  [DEPTH];
    sts_pkg::t_stats r_stats [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_key_en) begin
            r_keys[i_wr_addr] <= i_wr_key;
        end
        o_rd_key <= r_keys[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_stats[i_wr_addr] <= i_wr_stats;
        end
        o_rd_stats <= r_stats[i_rd_addr];
    end

endmodule

### src/scope_timing_stats_table.sv
// Scope timing statistics table. Pulse start while busy is low; exactly one result
// follows, shown for a single cycle with o_valid high, and the receiver cannot stall it.
// A clear empties the table and goes straight to its result. A sample is scaled first,
// then the key search walks the key memory one slot per cycle over the N entries in use,
// until it finds the key or has passed them all. A new key is inserted at slot N; when
// the table is full the sample is dropped; for a key found in slot S the statistics
// entry is read, modified and written back. The moving-average step uses one 48x17
// multiply in a state of its own.
module scope_timing_stats_table #(
    parameter int TABLE_DEPTH = sts_pkg::TableDepth,
    parameter int KEY_WIDTH   = sts_pkg::KeyWidth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_req_type,
    input  logic [15:0] i_label_key,
    input  logic [5:0]  i_nesting_depth,
    input  logic [63:0] i_begin_ticks,
    input  logic [63:0] i_end_ticks,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [5:0]  o_entry_index,
    output logic [31:0] o_last_duration,
    output logic [31:0] o_average_duration,
    output logic [31:0] o_maximum_duration,
    output logic [31:0] o_sample_total,
    output logic [5:0]  o_depth_out
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCALE  = 8'b0000_0010,
        S_SEARCH = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_MUL1   = 8'b0001_0000,
        S_MUL2   = 8'b0010_0000,
        S_WRITE  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic [6:0]  r_valid_bits;
    logic [31:0] r_tick_scale;
    logic [16:0] r_alpha;

    logic [CW-1:0]        r_used;
    logic [CW-1:0]        r_scan;
    logic [AW-1:0]        r_slot;
    logic                 r_found;
    logic [KEY_WIDTH-1:0] r_key;
    logic [5:0]           r_depth;
    logic [31:0]          r_dur;
    logic                 r_rd_pend;
    logic [47:0]          r_diff;
    logic                 r_up;
    logic [47:0]          r_avg_old;
    logic [64:0]          r_prod;
    sts_pkg::t_stats      r_old;

    logic            r_valid;
    logic [1:0]      r_status;
    logic [5:0]      r_index;
    sts_pkg::t_stats r_res;

    logic                 scale_start, scale_done;
    logic [31:0]          scale_dur;
    logic [AW-1:0]        rd_addr;
    logic [KEY_WIDTH-1:0] rd_key;
    sts_pkg::t_stats      rd_stats;
    logic                 wr_en, wr_key_en;
    sts_pkg::t_stats      wr_stats;
    logic [63:0]          mask;
    logic [16:0]          alpha_sat;
    logic [47:0]          target;
    logic [47:0]          step_val;
    logic [47:0]          new_avg;

    always_comb begin
        if (r_valid_bits >= 7'd64) begin
            mask = '1;
        end else begin
            mask = (64'd1 << r_valid_bits[5:0]) - 64'd1;
        end
    end

    assign alpha_sat = (r_alpha > 17'd65536) ? 17'd65536 : r_alpha;
    assign target    = {r_dur, 16'd0};
    assign step_val  = r_prod[63:16];
    assign new_avg   = r_up ? (r_avg_old + step_val) : (r_avg_old - step_val);

    assign scale_start = (r_state == S_IDLE) && start && (i_req_type != sts_pkg::REQ_CLEAR);

    sts_scaler u_scaler (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scale_start),
        .i_ticks    ((i_end_ticks - i_begin_ticks) & mask),
        .i_scale    (r_tick_scale),
        .o_done     (scale_done),
        .o_duration (scale_dur)
    );

    assign rd_addr = (r_state == S_SEARCH) ? r_scan[AW-1:0] : r_slot;

    always_comb begin
        wr_stats = r_old;
        if (r_found) begin
            wr_stats.last    = r_dur;
            wr_stats.average = new_avg;
            wr_stats.maximum = (r_dur > r_old.maximum) ? r_dur : r_old.maximum;
            wr_stats.count   = (r_old.count != 32'hFFFF_FFFF) ? r_old.count + 32'd1
                                                               : r_old.count;
            wr_stats.depth   = r_depth;
        end else begin
            wr_stats.last    = r_dur;
            wr_stats.average = target;
            wr_stats.maximum = r_dur;
            wr_stats.count   = 32'd1;
            wr_stats.depth   = r_depth;
        end
    end

    assign wr_en     = (r_state == S_WRITE);
    assign wr_key_en = wr_en && !r_found;

    sts_mem #(
        .DEPTH (TABLE_DEPTH),
        .KW    (KEY_WIDTH)
    ) u_mem (
        .i_clk       (i_clk),
        .i_rd_addr   (rd_addr),
        .o_rd_key    (rd_key),
        .o_rd_stats  (rd_stats),
        .i_wr_en     (wr_en),
        .i_wr_key_en (wr_key_en),
        .i_wr_addr   (r_slot),
        .i_wr_key    (r_key),
        .i_wr_stats  (wr_stats)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_req_type == sts_pkg::REQ_CLEAR) ? S_DONE : S_SCALE;
                end
            end
            S_SCALE:  if (scale_done) n_state = S_SEARCH;
            S_SEARCH: begin
                if (r_rd_pend && rd_key == r_key) begin
                    n_state = S_READ;
                end else if (r_scan >= r_used) begin
                    n_state = (r_used < CW'(TABLE_DEPTH)) ? S_WRITE : S_DONE;
                end
            end
            S_READ:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_WRITE;
            S_WRITE: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid_bits <= sts_pkg::VALID_BITS_RST;
            r_tick_scale <= sts_pkg::TICK_SCALE_RST;
            r_alpha      <= sts_pkg::ALPHA_RST;
            r_used       <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    sts_pkg::REG_VALID_BITS: r_valid_bits <= i_cfg_data[6:0];
                    sts_pkg::REG_TICK_SCALE: r_tick_scale <= i_cfg_data;
                    sts_pkg::REG_ALPHA:      r_alpha      <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (r_state == S_IDLE && start && i_req_type == sts_pkg::REQ_CLEAR) begin
                r_used <= '0;
            end
            if (wr_key_en) begin
                r_used <= r_used + CW'(1);
            end
            if (r_state == S_DONE) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_key     <= i_label_key[KEY_WIDTH-1:0];
                r_depth   <= i_nesting_depth;
                r_scan    <= '0;
                r_found   <= 1'b0;
                r_rd_pend <= 1'b0;
                r_status  <= sts_pkg::ST_CLEARED;
                r_index   <= '0;
                r_res     <= '0;
                r_dur     <= '0;
            end
            S_SCALE: r_dur <= scale_dur;
            S_SEARCH: begin
                if (r_rd_pend && rd_key == r_key) begin
                    r_found <= 1'b1;
                    r_slot  <= AW'(r_scan - CW'(1));
                end else if (r_scan >= r_used) begin
                    r_slot   <= r_used[AW-1:0];
                    r_status <= sts_pkg::ST_DROPPED;
                    r_res    <= sts_pkg::t_stats'{last: r_dur, default: '0};
                end else begin
                    r_rd_pend <= 1'b1;
                    r_scan    <= r_scan + CW'(1);
                end
            end
            S_READ: ;
            S_MUL1: begin
                r_old     <= rd_stats;
                r_avg_old <= rd_stats.average;
                if (target >= rd_stats.average) begin
                    r_up   <= 1'b1;
                    r_diff <= target - rd_stats.average;
                end else begin
                    r_up   <= 1'b0;
                    r_diff <= rd_stats.average - target;
                end
            end
            S_MUL2: begin
                r_prod <= 65'(r_diff) * 65'(alpha_sat);
            end
            S_WRITE: begin
                r_status <= r_found ? sts_pkg::ST_UPDATED : sts_pkg::ST_INSERTED;
                r_index  <= 6'(r_slot);
                r_res    <= wr_stats;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    assign busy               = (r_state != S_IDLE);
    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_entry_index      = r_index;
    assign o_last_duration    = r_res.last;
    assign o_average_duration = r_res.average[47:16];
    assign o_maximum_duration = r_res.maximum;
    assign o_sample_total     = r_res.count;
    assign o_depth_out        = r_res.depth;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result held more than one cycle");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_key_en |-> r_used < CW'(TABLE_DEPTH))
        else $error("insert into full table");

endmodule
